// File: sv/pps_pkg.sv
// Shared types, widths and constants for the pure pursuit steering unit.
// No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

  localparam int MAX_WAYPOINTS = 1024;
  localparam int ADDR_W        = 10;
  localparam int COORD_W       = 24;
  localparam int OFS_W         = COORD_W + 1;
  localparam int CNT_W         = 11;
  localparam int LA_W          = 23;
  localparam int GAIN_W        = 16;
  localparam int STEER_W       = 16;
  localparam int HEAD_W        = 16;
  localparam int CW            = 28;
  localparam int PW            = 2 * CW;
  localparam int ZW            = 16;
  localparam int CORDIC_STEPS  = 14;
  localparam int IT_W          = 4;
  localparam int QUO_W         = 17;
  localparam int NUM_SHIFT     = 13;
  localparam int SCALE_W       = 16;
  localparam int SCALE_SHIFT   = 15;
  localparam int CORDIC_SCALE  = 19898;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd2;

  localparam logic [CNT_W-1:0]  COUNT_RESET = 11'd0;
  localparam logic [LA_W-1:0]   LA_RESET    = 23'd6144;
  localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd4096;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POSE = 1'b1;

  typedef enum logic [2:0] {
    MS_LA, MS_DX, MS_DY, MS_LX, MS_LY, MS_GAIN
  } mul_sel_t;

  typedef struct packed {
    logic     start_pose;
    logic     load_wp;
    logic     ld_l2;
    logic     walk_init;
    logic     ld_diff;
    logic     ld_sqx;
    logic     walk_step;
    logic     cr_init;
    logic     cr_step;
    logic     sc_x;
    logic     sc_y;
    logic     ld_den;
    logic     ld_num;
    logic     dv_init;
    logic     dv_step;
    logic     ld_out;
    mul_sel_t mul_sel;
  } pps_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic walk_more;
    logic cr_last;
    logic dv_skip;
    logic dv_last;
    logic out_busy;
  } pps_sts_t;

  function automatic logic [ZW-1:0] atan_lut(input logic [IT_W-1:0] i);
    logic [ZW-1:0] v;
    unique case (i)
      4'd0:    v = 16'd8192;
      4'd1:    v = 16'd4836;
      4'd2:    v = 16'd2555;
      4'd3:    v = 16'd1297;
      4'd4:    v = 16'd651;
      4'd5:    v = 16'd326;
      4'd6:    v = 16'd163;
      4'd7:    v = 16'd81;
      4'd8:    v = 16'd41;
      4'd9:    v = 16'd20;
      4'd10:   v = 16'd10;
      4'd11:   v = 16'd5;
      4'd12:   v = 16'd3;
      4'd13:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/pps_ctrl.sv
// Sequencer for the pure pursuit steering unit.
// Depends on pps_pkg; drives commands into pps_datapath.
`timescale 1ns / 1ps

module pps_ctrl
  import pps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_opcode,
  output logic     in_stall,
  input  pps_sts_t sts,
  output pps_cmd_t cmd
);

  typedef enum logic [18:0] {
    S_IDLE    = 19'd1 << 0,
    S_LA_MUL  = 19'd1 << 1,
    S_LA_LD   = 19'd1 << 2,
    S_D_RD    = 19'd1 << 3,
    S_D_DIFF  = 19'd1 << 4,
    S_D_SQX   = 19'd1 << 5,
    S_D_SQY   = 19'd1 << 6,
    S_D_SUM   = 19'd1 << 7,
    S_CR_INIT = 19'd1 << 8,
    S_CR_ROT  = 19'd1 << 9,
    S_SC_X    = 19'd1 << 10,
    S_SC_Y    = 19'd1 << 11,
    S_DN_X    = 19'd1 << 12,
    S_DN_Y    = 19'd1 << 13,
    S_DN_SUM  = 19'd1 << 14,
    S_NM_MUL  = 19'd1 << 15,
    S_NM_LD   = 19'd1 << 16,
    S_DV      = 19'd1 << 17,
    S_FINISH  = 19'd1 << 18
  } state_t;

  state_t state_r, state_nxt;
  logic   dv_run_r, dv_run_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    dv_run_nxt = dv_run_r;
    cmd        = '0;
    cmd.mul_sel = MS_LA;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_POSE) begin
            cmd.start_pose = 1'b1;
            state_nxt = sts.cnt_zero ? S_FINISH : S_LA_MUL;
          end else begin
            cmd.load_wp = 1'b1;
          end
        end
      end
      S_LA_MUL: begin
        cmd.mul_sel = MS_LA;
        state_nxt = S_LA_LD;
      end
      S_LA_LD: begin
        cmd.ld_l2 = 1'b1;
        cmd.walk_init = 1'b1;
        state_nxt = S_D_RD;
      end
      S_D_RD:   state_nxt = S_D_DIFF;
      S_D_DIFF: begin
        cmd.ld_diff = 1'b1;
        state_nxt = S_D_SQX;
      end
      S_D_SQX: begin
        cmd.mul_sel = MS_DX;
        state_nxt = S_D_SQY;
      end
      S_D_SQY: begin
        cmd.mul_sel = MS_DY;
        cmd.ld_sqx = 1'b1;
        state_nxt = S_D_SUM;
      end
      S_D_SUM: begin
        cmd.walk_step = 1'b1;
        state_nxt = sts.walk_more ? S_D_RD : S_CR_INIT;
      end
      S_CR_INIT: begin
        cmd.cr_init = 1'b1;
        state_nxt = S_CR_ROT;
      end
      S_CR_ROT: begin
        cmd.cr_step = 1'b1;
        if (sts.cr_last) state_nxt = S_SC_X;
      end
      S_SC_X: begin
        cmd.sc_x = 1'b1;
        state_nxt = S_SC_Y;
      end
      S_SC_Y: begin
        cmd.sc_y = 1'b1;
        state_nxt = S_DN_X;
      end
      S_DN_X: begin
        cmd.mul_sel = MS_LX;
        state_nxt = S_DN_Y;
      end
      S_DN_Y: begin
        cmd.mul_sel = MS_LY;
        cmd.ld_sqx = 1'b1;
        state_nxt = S_DN_SUM;
      end
      S_DN_SUM: begin
        cmd.ld_den = 1'b1;
        state_nxt = S_NM_MUL;
      end
      S_NM_MUL: begin
        cmd.mul_sel = MS_GAIN;
        state_nxt = S_NM_LD;
      end
      S_NM_LD: begin
        cmd.ld_num = 1'b1;
        dv_run_nxt = 1'b0;
        state_nxt = S_DV;
      end
      S_DV: begin
        if (!dv_run_r) begin
          cmd.dv_init = 1'b1;
          if (sts.dv_skip) state_nxt = S_FINISH;
          else dv_run_nxt = 1'b1;
        end else begin
          cmd.dv_step = 1'b1;
          if (sts.dv_last) state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.ld_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dv_run_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      dv_run_r <= dv_run_nxt;
    end
  end

endmodule

// File: sv/pps_datapath.sv
// Datapath: waypoint tables, config registers, distance walk, CORDIC, divider.
// Depends on pps_pkg; driven by pps_ctrl.
`timescale 1ns / 1ps

module pps_datapath
  import pps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [ADDR_W-1:0]         in_wp_index,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic [HEAD_W-1:0]         in_heading,
  input  pps_cmd_t                  cmd,
  output pps_sts_t                  sts,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic signed [STEER_W-1:0] out_steer,
  output logic [ADDR_W-1:0]         out_goal_index,
  output logic                      out_no_path,
  output logic                      out_saturated
);

  logic [CNT_W-1:0]  count_r;
  logic [LA_W-1:0]   la_r;
  logic [GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      la_r    <= LA_RESET;
      gain_r  <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COUNT:     count_r <= cfg_wdata[CNT_W-1:0];
        CFG_LOOKAHEAD: la_r    <= cfg_wdata[LA_W-1:0];
        CFG_GAIN:      gain_r  <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] cnt_in;
  assign cnt_in = (count_r > CNT_W'(MAX_WAYPOINTS)) ? CNT_W'(MAX_WAYPOINTS) : count_r;

  // waypoint tables
  logic signed [COORD_W-1:0] mem_x [MAX_WAYPOINTS];
  logic signed [COORD_W-1:0] mem_y [MAX_WAYPOINTS];
  logic signed [COORD_W-1:0] rdx_r, rdy_r;
  logic [ADDR_W-1:0]         idx_r;

  always_ff @(posedge clk) begin
    if (cmd.load_wp) begin
      mem_x[in_wp_index] <= in_x_coord;
      mem_y[in_wp_index] <= in_y_coord;
    end
    rdx_r <= mem_x[idx_r];
    rdy_r <= mem_y[idx_r];
  end

  function automatic logic [CW-1:0] mag_cw(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  logic signed [COORD_W-1:0] px_r, py_r;
  logic [HEAD_W-1:0]         hd_r;
  logic [CNT_W-1:0]          cnt_r, step_r;
  logic [ADDR_W-1:0]         goal_r;
  logic                      found_r, nopath_r;
  logic signed [OFS_W-1:0]   dx_r, dy_r;
  logic [PW-1:0]             prod_r, sqx_r, best_r, l2_r, den_r, num_r, p_r;
  logic [PW-1:0]             sum;
  logic signed [CW-1:0]      cx_r, cy_r, lx_r, ly_r;
  logic signed [ZW-1:0]      z_r;
  logic [IT_W-1:0]           it_r;
  logic [QUO_W-1:0]          q_r, nbits_r;
  logic                      dz_r, ovf_r;
  logic [CW-1:0]             mul_a, mul_b;

  always_comb begin
    unique case (cmd.mul_sel)
      MS_LA: begin
        mul_a = CW'(la_r);
        mul_b = CW'(la_r);
      end
      MS_DX: begin
        mul_a = mag_cw(CW'(dx_r));
        mul_b = mul_a;
      end
      MS_DY: begin
        mul_a = mag_cw(CW'(dy_r));
        mul_b = mul_a;
      end
      MS_LX: begin
        mul_a = mag_cw(lx_r);
        mul_b = mul_a;
      end
      MS_LY: begin
        mul_a = mag_cw(ly_r);
        mul_b = mul_a;
      end
      MS_GAIN: begin
        mul_a = CW'(gain_r);
        mul_b = mag_cw(ly_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sum = sqx_r + prod_r;

  // distance walk decisions
  logic              upd_best, scan_last, more_adv;
  logic [CNT_W-1:0]  goal_inc;
  logic [ADDR_W-1:0] goal_wrap;

  assign upd_best  = (idx_r == '0) || (sum < best_r);
  assign scan_last = ({1'b0, idx_r} == (cnt_r - CNT_W'(1)));
  assign more_adv  = (step_r < cnt_r) && (sum < l2_r);
  assign goal_inc  = {1'b0, goal_r} + CNT_W'(1);
  assign goal_wrap = (goal_inc >= cnt_r) ? '0 : goal_inc[ADDR_W-1:0];

  // CORDIC setup
  logic [HEAD_W-1:0]    ang, ang_q;
  logic [1:0]           quad;
  logic signed [CW-1:0] ox, oy, xs, ys;
  logic signed [ZW-1:0] atan_s;

  assign ang    = HEAD_W'(0) - hd_r;
  assign ang_q  = ang + HEAD_W'(8192);
  assign quad   = ang_q[15:14];
  assign ox     = CW'(dx_r);
  assign oy     = CW'(dy_r);
  assign xs     = cx_r >>> it_r;
  assign ys     = cy_r >>> it_r;
  assign atan_s = $signed(atan_lut(it_r));

  logic signed [CW-1:0]           sc_in;
  logic signed [CW+SCALE_W-1:0]   sc_prod;
  logic signed [CW+SCALE_W-1:0]   sc_rnd;
  assign sc_in   = cmd.sc_y ? cy_r : cx_r;
  assign sc_prod = sc_in * $signed(SCALE_W'(CORDIC_SCALE));
  assign sc_rnd  = (sc_prod + (CW+SCALE_W)'(16384)) >>> SCALE_SHIFT;

  // divider
  logic [PW-1:0] dv_trial;
  logic          dv_ovf;
  assign dv_ovf   = (PW'(num_r[PW-1:QUO_W]) >= den_r);
  assign dv_trial = {p_r[PW-2:0], nbits_r[QUO_W-1]};

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.start_pose) begin
      px_r <= in_x_coord;
      py_r <= in_y_coord;
      hd_r <= in_heading;
      cnt_r <= cnt_in;
    end
    if (cmd.ld_l2)  l2_r <= prod_r;
    if (cmd.walk_init) begin
      idx_r  <= found_r ? goal_r : '0;
      step_r <= '0;
    end
    if (cmd.ld_diff) begin
      dx_r <= OFS_W'(rdx_r) - OFS_W'(px_r);
      dy_r <= OFS_W'(rdy_r) - OFS_W'(py_r);
    end
    if (cmd.ld_sqx) sqx_r <= prod_r;
    if (cmd.walk_step) begin
      if (!found_r) begin
        if (upd_best) best_r <= sum;
        if (scan_last) begin
          idx_r  <= upd_best ? idx_r : goal_r;
          step_r <= '0;
        end else begin
          idx_r <= idx_r + ADDR_W'(1);
        end
      end else if (more_adv) begin
        idx_r  <= goal_wrap;
        step_r <= step_r + CNT_W'(1);
      end
    end
    if (cmd.cr_init) begin
      z_r  <= $signed(ang - {quad, 14'b0});
      it_r <= '0;
      unique case (quad)
        2'd0: begin cx_r <= ox;  cy_r <= oy;  end
        2'd1: begin cx_r <= -oy; cy_r <= ox;  end
        2'd2: begin cx_r <= -ox; cy_r <= -oy; end
        2'd3: begin cx_r <= oy;  cy_r <= -ox; end
        default: ;
      endcase
    end
    if (cmd.cr_step) begin
      it_r <= it_r + IT_W'(1);
      if (z_r >= 0) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        z_r  <= z_r - atan_s;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        z_r  <= z_r + atan_s;
      end
    end
    if (cmd.sc_x) lx_r <= sc_rnd[CW-1:0];
    if (cmd.sc_y) ly_r <= sc_rnd[CW-1:0];
    if (cmd.ld_den) den_r <= sum;
    if (cmd.ld_num) num_r <= prod_r << NUM_SHIFT;
    if (cmd.dv_init) begin
      dz_r    <= (den_r == '0);
      ovf_r   <= dv_ovf;
      p_r     <= PW'(num_r[PW-1:QUO_W]);
      nbits_r <= num_r[QUO_W-1:0];
      q_r     <= '0;
      it_r    <= IT_W'(0);
    end
    if (cmd.dv_step) begin
      nbits_r <= nbits_r << 1;
      if (dv_trial >= den_r) begin
        p_r <= dv_trial - den_r;
        q_r <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        p_r <= dv_trial;
        q_r <= {q_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  // divider step count
  logic [4:0] dv_cnt_r;
  always_ff @(posedge clk) begin
    if (cmd.dv_init) dv_cnt_r <= 5'(QUO_W - 1);
    else if (cmd.dv_step) dv_cnt_r <= dv_cnt_r - 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r   <= '0;
      found_r  <= 1'b0;
      nopath_r <= 1'b0;
    end else begin
      if (cmd.start_pose) begin
        nopath_r <= (cnt_in == '0);
        if (cnt_in != '0 && {1'b0, goal_r} >= cnt_in) found_r <= 1'b0;
      end
      if (cmd.walk_step) begin
        if (!found_r) begin
          if (upd_best) goal_r <= idx_r;
          if (scan_last) found_r <= 1'b1;
        end else if (more_adv) begin
          goal_r <= goal_wrap;
        end
      end
    end
  end

  // result
  logic signed [STEER_W-1:0] steer;
  logic                      sat;
  logic                      neg;
  assign neg = ly_r[CW-1];

  always_comb begin
    steer = '0;
    sat   = 1'b0;
    priority if (nopath_r) begin
      steer = '0;
      sat   = 1'b0;
    end else if (dz_r) begin
      steer = '0;
      sat   = 1'b1;
    end else if (ovf_r) begin
      steer = neg ? 16'sh8000 : 16'sh7FFF;
      sat   = 1'b1;
    end else if (neg) begin
      if (q_r > QUO_W'(32768)) begin
        steer = 16'sh8000;
        sat   = 1'b1;
      end else begin
        steer = $signed(STEER_W'(QUO_W'(0) - q_r));
      end
    end else begin
      if (q_r > QUO_W'(32767)) begin
        steer = 16'sh7FFF;
        sat   = 1'b1;
      end else begin
        steer = $signed(q_r[STEER_W-1:0]);
      end
    end
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_steer      <= steer;
      out_goal_index <= goal_r;
      out_no_path    <= nopath_r;
      out_saturated  <= sat;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.cnt_zero  = (cnt_in == '0);
  assign sts.walk_more = !found_r || more_adv;
  assign sts.cr_last   = (it_r == IT_W'(CORDIC_STEPS - 1));
  assign sts.dv_skip   = (den_r == '0) || dv_ovf;
  assign sts.dv_last   = (dv_cnt_r == 5'd0);
  assign sts.out_busy  = out_valid_r && out_stall;

endmodule

// File: sv/pure_pursuit_steering_unit.sv
// Pure pursuit steering unit, top level. A load is accepted with no result.
// A pose runs E distance evaluations before the CORDIC and divider, E =
// 1 + advance steps (up to N), plus N more on a nearest search; N = waypoint_count.
// Zero denominator or quotient overflow skips the divider steps; no path goes straight
// to the result. One pose in flight; next transaction accepted the cycle after.
// Reset (rst_n low, synchronous) clears goal state and restores config defaults.
`timescale 1ns / 1ps

module pure_pursuit_steering_unit
  import pps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [ADDR_W-1:0]         in_wp_index,
  input  logic signed [COORD_W-1:0] in_x_coord,
  input  logic signed [COORD_W-1:0] in_y_coord,
  input  logic [HEAD_W-1:0]         in_heading,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [STEER_W-1:0] out_steer,
  output logic [ADDR_W-1:0]         out_goal_index,
  output logic                      out_no_path,
  output logic                      out_saturated
);

  pps_cmd_t cmd;
  pps_sts_t sts;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pps_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_wp_index    (in_wp_index),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_heading     (in_heading),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_steer      (out_steer),
    .out_goal_index (out_goal_index),
    .out_no_path    (out_no_path),
    .out_saturated  (out_saturated)
  );

  a_pose_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == OP_POSE) |=> in_stall)
    else $error("pose transaction did not occupy the unit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");

  a_no_path_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_path |-> (out_steer == '0) && !out_saturated)
    else $error("no-path result carries steering");

endmodule
